FILE: design/jsv_pkg.sv
// shared types and constants for the json syntax validator
// no dependencies
package jsv_pkg;

  typedef enum logic [4:0] {
    S_START, S_OBJ_OPEN, S_OBJ_KEY, S_KEY, S_COLON, S_VALUE, S_ARR_OPEN,
    S_STR, S_AFTER, S_TRUE, S_FALSE, S_NULL, S_MINUS, S_ZERO, S_INT,
    S_DOT, S_FRAC, S_EXP_E, S_EXP_SIGN, S_EXP, S_DONE, S_ERR, S_ERR_DEPTH
  } lex_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        json_valid;
    logic [15:0] error_offset;
    logic        depth_overflow;
  } out_item_t;

  // byte classes found by the front part
  typedef struct packed {
    logic       is_ws;
    logic       is_digit;
    logic [7:0] ch;
    logic       last;
  } cls_item_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UPPER_E = 8'h45;

  function automatic logic [7:0] lit_char(input lex_state_t s, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (s)
      S_TRUE: begin
        case (idx)
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      S_FALSE: begin
        case (idx)
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      S_NULL: begin
        case (idx)
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: design/jsv_front.sv
// front part: accepts bytes, classifies them, and holds them in a short queue
// depends on jsv_pkg
module jsv_front
  import jsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      q_valid,
  input  logic      q_take,
  output cls_item_t q_item
);

  cls_item_t  slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  cls_item_t  cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.ch = in_item.data_byte;
    cls.last = in_item.last_byte;
    cls.is_ws = (in_item.data_byte == CH_SPACE) || (in_item.data_byte == CH_TAB) ||
                (in_item.data_byte == CH_LF) || (in_item.data_byte == CH_CR);
    cls.is_digit = (in_item.data_byte >= "0") && (in_item.data_byte <= "9");
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= cls;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd2 && !do_pop) |=> full)
    else $error("queue lost fullness");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !do_pop)
    else $error("pop from empty queue");

endmodule

FILE: design/jsv_back.sv
// back part: lexer state machine, container stack and result register
// depends on jsv_pkg
module jsv_back
  import jsv_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic [6:0] max_nesting,
  input  logic      q_valid,
  output logic      q_take,
  input  cls_item_t q_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  lex_state_t lexer_state, lexer_state_next;
  logic [DW-1:0] nesting_depth, nesting_depth_next;
  logic escape_parity, escape_parity_next;
  logic [2:0] literal_index, literal_index_next;
  logic [OFFSET_BITS-1:0] byte_offset, first_error_offset;
  logic error_seen;

  logic stack_mem [STACK_DEPTH];
  logic top_bit;
  logic stk_we, stk_wd;
  logic [AW-1:0] stk_wa;

  logic out_valid;
  out_item_t res;
  logic step;

  logic [7:0] c;
  logic ws, dig;
  logic [DW:0] limit;
  logic top_obj, top_arr;
  logic [OFFSET_BITS-1:0] here_off;
  logic [15:0] off_sat, blen_sat;

  assign c   = q_item.ch;
  assign ws  = q_item.is_ws;
  assign dig = q_item.is_digit;

  // a result waits in out register; back stalls only when it must deliver another
  assign q_take = q_valid && !(out_valid && !pop && q_item.last);
  assign step   = q_take;
  assign empty  = !out_valid;
  assign out_item = res;

  assign limit = (int'(max_nesting) > STACK_DEPTH) ? (DW+1)'(STACK_DEPTH) :
                 (DW+1)'(max_nesting);
  assign top_obj = (nesting_depth != '0) && top_bit;
  assign top_arr = (nesting_depth != '0) && !top_bit;

  // top of stack mirrored in a register; memory holds entries below
  logic [AW-1:0] rd_addr;
  logic rd_data;
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    rd_data <= stack_mem[rd_addr];
  end

  // top_bit follows pushes, and after a pop comes from memory read
  logic pop_pending;
  logic top_reg;
  assign top_bit = pop_pending ? rd_data : top_reg;

  logic do_push, do_popc, push_kind;

  always_comb begin
    lexer_state_next   = lexer_state;
    nesting_depth_next = nesting_depth;
    escape_parity_next = escape_parity;
    literal_index_next = literal_index;
    do_push  = 1'b0;
    do_popc  = 1'b0;
    push_kind = 1'b0;
    unique case (lexer_state)
      S_START: begin
        if (c == "{") begin do_push = 1'b1; push_kind = 1'b1; end
        else if (!ws) lexer_state_next = S_ERR;
      end
      S_OBJ_OPEN: begin
        if (c == "}") do_popc = 1'b1;
        else if (c == CH_QUOTE) begin escape_parity_next = 1'b0; lexer_state_next = S_KEY; end
        else if (!ws) lexer_state_next = S_ERR;
      end
      S_OBJ_KEY: begin
        if (c == CH_QUOTE) begin escape_parity_next = 1'b0; lexer_state_next = S_KEY; end
        else if (!ws) lexer_state_next = S_ERR;
      end
      S_KEY, S_STR: begin
        if (c == CH_QUOTE && !escape_parity) begin
          escape_parity_next = 1'b0;
          lexer_state_next = (lexer_state == S_KEY) ? S_COLON : S_AFTER;
        end else begin
          escape_parity_next = (c == CH_BSLASH) ? ~escape_parity : 1'b0;
        end
      end
      S_COLON: begin
        if (c == ":") lexer_state_next = S_VALUE;
        else if (!ws) lexer_state_next = S_ERR;
      end
      S_VALUE, S_ARR_OPEN: begin
        if (lexer_state == S_ARR_OPEN && c == "]") do_popc = 1'b1;
        else if (!ws) begin
          if (c == CH_QUOTE) begin escape_parity_next = 1'b0; lexer_state_next = S_STR; end
          else if (c == "{") begin do_push = 1'b1; push_kind = 1'b1; end
          else if (c == "[") begin do_push = 1'b1; push_kind = 1'b0; end
          else if (c == "t") begin literal_index_next = 3'd1; lexer_state_next = S_TRUE; end
          else if (c == "f") begin literal_index_next = 3'd1; lexer_state_next = S_FALSE; end
          else if (c == "n") begin literal_index_next = 3'd1; lexer_state_next = S_NULL; end
          else if (c == "-") lexer_state_next = S_MINUS;
          else if (c == "0") lexer_state_next = S_ZERO;
          else if (dig) lexer_state_next = S_INT;
          else lexer_state_next = S_ERR;
        end
      end
      S_TRUE, S_FALSE, S_NULL: begin
        if (c == lit_char(lexer_state, literal_index)) begin
          if ((lexer_state == S_FALSE && literal_index == 3'd4) ||
              (lexer_state != S_FALSE && literal_index == 3'd3)) begin
            literal_index_next = 3'd0;
            lexer_state_next = S_AFTER;
          end else begin
            literal_index_next = literal_index + 3'd1;
          end
        end else begin
          literal_index_next = 3'd0;
          lexer_state_next = S_ERR;
        end
      end
      S_MINUS: begin
        if (c == "0") lexer_state_next = S_ZERO;
        else if (dig) lexer_state_next = S_INT;
        else lexer_state_next = S_ERR;
      end
      S_DOT: lexer_state_next = dig ? S_FRAC : S_ERR;
      S_EXP_E: begin
        if (c == "+" || c == "-") lexer_state_next = S_EXP_SIGN;
        else lexer_state_next = dig ? S_EXP : S_ERR;
      end
      S_EXP_SIGN: lexer_state_next = dig ? S_EXP : S_ERR;
      S_DONE: if (!ws) lexer_state_next = S_ERR;
      S_ZERO, S_INT, S_FRAC, S_EXP, S_AFTER: begin
        if ((lexer_state == S_INT || lexer_state == S_FRAC || lexer_state == S_EXP) && dig) begin
          lexer_state_next = lexer_state;
        end else if ((lexer_state == S_ZERO || lexer_state == S_INT) && c == ".") begin
          lexer_state_next = S_DOT;
        end else if ((lexer_state == S_ZERO || lexer_state == S_INT || lexer_state == S_FRAC) &&
                     (c == "e" || c == CH_UPPER_E)) begin
          lexer_state_next = S_EXP_E;
        end else begin
          lexer_state_next = S_AFTER;
          if (ws) lexer_state_next = S_AFTER;
          else if (c == ",") lexer_state_next = top_obj ? S_OBJ_KEY : (top_arr ? S_VALUE : S_ERR);
          else if (c == "}" && top_obj) do_popc = 1'b1;
          else if (c == "]" && top_arr) do_popc = 1'b1;
          else lexer_state_next = S_ERR;
        end
      end
      default: lexer_state_next = S_ERR;
    endcase
    if (do_push) begin
      if ({1'b0, nesting_depth} >= limit) lexer_state_next = S_ERR_DEPTH;
      else begin
        nesting_depth_next = nesting_depth + 1'b1;
        lexer_state_next = push_kind ? S_OBJ_OPEN : S_ARR_OPEN;
      end
    end
    if (do_popc) begin
      nesting_depth_next = nesting_depth - 1'b1;
      lexer_state_next = (nesting_depth_next == '0) ? S_DONE : S_AFTER;
    end
  end

  logic real_push, real_pop;
  assign real_push = step && !error_seen && do_push && (lexer_state_next != S_ERR_DEPTH);
  assign real_pop  = step && !error_seen && do_popc;
  // on push, old top goes to memory at depth-1
  assign stk_we = real_push && (nesting_depth != '0);
  assign stk_wa = AW'(nesting_depth - 1'b1);
  assign stk_wd = top_bit;
  // after pop, new top is entry at depth-2
  assign rd_addr = AW'(nesting_depth - 2'd2);

  assign here_off = byte_offset;
  assign blen_sat = ((byte_offset != OFF_MAX) ? byte_offset + 1'b1 : byte_offset) > 16'hffff
                    ? 16'hffff : 16'(((byte_offset != OFF_MAX) ? byte_offset + 1'b1 : byte_offset));
  assign off_sat = (first_error_offset > 16'hffff) ? 16'hffff : 16'(first_error_offset);

  logic err_now;
  assign err_now = (lexer_state_next == S_ERR) || (lexer_state_next == S_ERR_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      lexer_state <= S_START;
      nesting_depth <= '0;
      escape_parity <= 1'b0;
      literal_index <= 3'd0;
      byte_offset <= '0;
      error_seen <= 1'b0;
      first_error_offset <= '0;
      out_valid <= 1'b0;
      pop_pending <= 1'b0;
      top_reg <= 1'b0;
    end else begin
      if (out_valid && pop) out_valid <= 1'b0;
      if (step) begin
        if (real_push) begin
          top_reg <= push_kind;
          pop_pending <= 1'b0;
        end else if (real_pop) begin
          pop_pending <= 1'b1;
        end else if (pop_pending) begin
          top_reg <= rd_data;
          pop_pending <= 1'b0;
        end
        if (q_item.last) begin
          out_valid <= 1'b1;
          if (error_seen) begin
            res.json_valid <= 1'b0;
            res.error_offset <= off_sat;
            res.depth_overflow <= (lexer_state == S_ERR_DEPTH);
          end else if (err_now) begin
            res.json_valid <= 1'b0;
            res.error_offset <= (here_off > 16'hffff) ? 16'hffff : 16'(here_off);
            res.depth_overflow <= (lexer_state_next == S_ERR_DEPTH);
          end else if (lexer_state_next != S_DONE) begin
            res.json_valid <= 1'b0;
            res.error_offset <= blen_sat;
            res.depth_overflow <= 1'b0;
          end else begin
            res.json_valid <= 1'b1;
            res.error_offset <= 16'd0;
            res.depth_overflow <= 1'b0;
          end
          lexer_state <= S_START;
          nesting_depth <= '0;
          escape_parity <= 1'b0;
          literal_index <= 3'd0;
          byte_offset <= '0;
          error_seen <= 1'b0;
          first_error_offset <= '0;
          pop_pending <= 1'b0;
        end else begin
          if (byte_offset != OFF_MAX) byte_offset <= byte_offset + 1'b1;
          if (!error_seen) begin
            lexer_state <= lexer_state_next;
            nesting_depth <= nesting_depth_next;
            escape_parity <= escape_parity_next;
            literal_index <= literal_index_next;
            if (err_now) begin
              error_seen <= 1'b1;
              first_error_offset <= here_off;
            end
          end
        end
      end else if (pop_pending) begin
        top_reg <= rd_data;
        pop_pending <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (step && q_item.last) |=> out_valid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, nesting_depth} <= (DW+1)'(STACK_DEPTH)))
    else $error("depth beyond stack");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop && q_valid && q_item.last) |-> !q_take)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (rst)
    error_seen |-> (lexer_state == S_ERR || lexer_state == S_ERR_DEPTH))
    else $error("error flag without error state");

endmodule

FILE: design/json_syntax_validator_unit.sv
// Streaming JSON syntax validator. Takes one byte per cycle unless a last
// byte meets an unpopped verdict; the sustained rate is one item per cycle,
// set by the lexer step on the state and stack top. A two-entry queue sits
// between byte classification and the lexer, and the result register lets the
// next text start while a verdict waits. One result per text, on its last byte.
// depends on jsv_pkg, jsv_front, jsv_back
module json_syntax_validator_unit
  import jsv_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);

  logic [6:0] max_nesting;
  logic       q_valid, q_take;
  cls_item_t  q_item;

  always_ff @(posedge clk) begin
    if (rst) max_nesting <= 7'd64;
    else if (cfg_we) max_nesting <= cfg_data;
  end

  jsv_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  jsv_back #(.STACK_DEPTH(STACK_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk(clk), .rst(rst), .max_nesting(max_nesting),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for json_syntax_validator_unit: directed and random
// json texts, results checked against a behavioral predictor of the lexer
// depends on jsv_pkg and the design files
module tb_top;
  import jsv_pkg::*;

  typedef logic [7:0] u8_t;

  localparam longint CYCLE_LIMIT = 500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  in_item_t   in_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  always #5 clk = ~clk;

  json_syntax_validator_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [6:0]  nest_limit = 7'd64;
  lex_state_t  lx_state = S_START;
  bit          lx_stack [64];
  int          lx_depth = 0;
  bit          lx_parity = 0;
  int          lx_lit = 0;
  logic [15:0] lx_offset = '0;
  bit          lx_err = 0;
  logic [15:0] lx_err_offset = '0;

  out_item_t   verdict_q[$];
  int          fail_cnt = 0;
  int          verdicts_seen = 0;
  int          bytes_sent = 0;
  int          texts_sent = 0;
  longint      cyc = 0;
  bit          no_gaps = 0;
  bit          pop_calm = 0;
  int          pop_hold = 0;

  function automatic bit is_space(u8_t c);
    return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB;
  endfunction

  function automatic bit is_num(u8_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit top_is(bit obj);
    return lx_depth != 0 && lx_stack[lx_depth-1] == obj;
  endfunction

  task automatic open_container(bit obj, lex_state_t nxt);
    int lim;
    lim = nest_limit > 64 ? 64 : nest_limit;
    if (lx_depth >= lim) begin
      lx_state = S_ERR_DEPTH;
    end else begin
      lx_stack[lx_depth] = obj;
      lx_depth++;
      lx_state = nxt;
    end
  endtask

  task automatic close_container();
    if (lx_depth > 0) lx_depth--;
    lx_state = lx_depth == 0 ? S_DONE : S_AFTER;
  endtask

  task automatic start_value(u8_t c);
    if (c == CH_QUOTE) begin
      lx_parity = 0;
      lx_state = S_STR;
    end else if (c == "{") begin
      open_container(1, S_OBJ_OPEN);
    end else if (c == "[") begin
      open_container(0, S_ARR_OPEN);
    end else if (c == "t") begin
      lx_lit = 1;
      lx_state = S_TRUE;
    end else if (c == "f") begin
      lx_lit = 1;
      lx_state = S_FALSE;
    end else if (c == "n") begin
      lx_lit = 1;
      lx_state = S_NULL;
    end else if (c == "-") begin
      lx_state = S_MINUS;
    end else if (c == "0") begin
      lx_state = S_ZERO;
    end else if (is_num(c)) begin
      lx_state = S_INT;
    end else begin
      lx_state = S_ERR;
    end
  endtask

  task automatic end_value(u8_t c);
    lx_state = S_AFTER;
    if (!is_space(c)) begin
      if (c == ",") begin
        lx_state = top_is(1) ? S_OBJ_KEY : (top_is(0) ? S_VALUE : S_ERR);
      end else if (c == "}" && top_is(1)) begin
        close_container();
      end else if (c == "]" && top_is(0)) begin
        close_container();
      end else begin
        lx_state = S_ERR;
      end
    end
  endtask

  task automatic string_char(u8_t c, output bit closed);
    closed = 0;
    if (c == CH_QUOTE && !lx_parity) begin
      closed = 1;
    end else begin
      lx_parity = (c == CH_BSLASH) ? ~lx_parity : 1'b0;
    end
  endtask

  task automatic literal_char(u8_t c, string word);
    if (lx_lit < word.len() && c == u8_t'(word[lx_lit])) begin
      lx_lit++;
      if (lx_lit == word.len()) begin
        lx_lit = 0;
        lx_state = S_AFTER;
      end
    end else begin
      lx_lit = 0;
      lx_state = S_ERR;
    end
  endtask

  task automatic lex_char(u8_t c);
    bit closed;
    case (lx_state)
      S_START: begin
        if (c == "{") open_container(1, S_OBJ_OPEN);
        else if (!is_space(c)) lx_state = S_ERR;
      end
      S_OBJ_OPEN: begin
        if (c == "}") close_container();
        else if (c == CH_QUOTE) begin
          lx_parity = 0;
          lx_state = S_KEY;
        end else if (!is_space(c)) lx_state = S_ERR;
      end
      S_OBJ_KEY: begin
        if (c == CH_QUOTE) begin
          lx_parity = 0;
          lx_state = S_KEY;
        end else if (!is_space(c)) lx_state = S_ERR;
      end
      S_KEY: begin
        string_char(c, closed);
        if (closed) begin
          lx_parity = 0;
          lx_state = S_COLON;
        end
      end
      S_COLON: begin
        if (c == ":") lx_state = S_VALUE;
        else if (!is_space(c)) lx_state = S_ERR;
      end
      S_VALUE: if (!is_space(c)) start_value(c);
      S_ARR_OPEN: begin
        if (c == "]") close_container();
        else if (!is_space(c)) start_value(c);
      end
      S_STR: begin
        string_char(c, closed);
        if (closed) begin
          lx_parity = 0;
          lx_state = S_AFTER;
        end
      end
      S_AFTER: end_value(c);
      S_TRUE: literal_char(c, "true");
      S_FALSE: literal_char(c, "false");
      S_NULL: literal_char(c, "null");
      S_MINUS: begin
        if (c == "0") lx_state = S_ZERO;
        else if (is_num(c)) lx_state = S_INT;
        else lx_state = S_ERR;
      end
      S_ZERO, S_INT: begin
        if (!(lx_state == S_INT && is_num(c))) begin
          if (c == ".") lx_state = S_DOT;
          else if (c == "e" || c == CH_UPPER_E) lx_state = S_EXP_E;
          else end_value(c);
        end
      end
      S_DOT: lx_state = is_num(c) ? S_FRAC : S_ERR;
      S_FRAC: begin
        if (!is_num(c)) begin
          if (c == "e" || c == CH_UPPER_E) lx_state = S_EXP_E;
          else end_value(c);
        end
      end
      S_EXP_E: begin
        if (c == "+" || c == "-") lx_state = S_EXP_SIGN;
        else lx_state = is_num(c) ? S_EXP : S_ERR;
      end
      S_EXP_SIGN: lx_state = is_num(c) ? S_EXP : S_ERR;
      S_EXP: if (!is_num(c)) end_value(c);
      S_DONE: if (!is_space(c)) lx_state = S_ERR;
      default: lx_state = S_ERR;
    endcase
  endtask

  task automatic predict_verdict(u8_t c, bit last);
    logic [15:0] here;
    out_item_t   v;
    here = lx_offset;
    if (lx_offset != 16'hffff) lx_offset++;
    if (!lx_err) begin
      lex_char(c);
      if (lx_state == S_ERR || lx_state == S_ERR_DEPTH) begin
        lx_err = 1;
        lx_err_offset = here;
      end
    end
    if (last) begin
      v = '0;
      if (lx_err) begin
        v.error_offset = lx_err_offset;
        v.depth_overflow = lx_state == S_ERR_DEPTH;
      end else if (lx_state != S_DONE) begin
        v.error_offset = lx_offset;
      end else begin
        v.json_valid = 1'b1;
      end
      verdict_q.push_back(v);
      lx_state = S_START;
      lx_depth = 0;
      lx_parity = 0;
      lx_lit = 0;
      lx_offset = '0;
      lx_err = 0;
      lx_err_offset = '0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(u8_t c, bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= '{data_byte: c, last_byte: last};
    do @(posedge clk); while (full);
    predict_verdict(c, last);
    bytes_sent++;
  endtask

  task automatic send_text(ref u8_t q[$]);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
    texts_sent++;
  endtask

  task automatic send_str(string s);
    u8_t q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_text(q);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_limit(logic [6:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    nest_limit = v;
  endtask

  // {"a": + n brackets + closes + }
  task automatic send_nest(int n);
    u8_t q[$];
    q = '{"{", CH_QUOTE, "a", CH_QUOTE, ":"};
    repeat (n) q.push_back("[");
    repeat (n) q.push_back("]");
    q.push_back("}");
    send_text(q);
  endtask

  task automatic add_space(ref u8_t q[$]);
    u8_t sp [4];
    sp = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    if ($urandom_range(0, 99) < 30) q.push_back(sp[$urandom_range(0, 3)]);
  endtask

  task automatic add_string(ref u8_t q[$]);
    u8_t c;
    u8_t esc [3];
    esc = '{CH_BSLASH, CH_QUOTE, "n"};
    q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 99) < 20) begin
        q.push_back(CH_BSLASH);
        q.push_back(esc[$urandom_range(0, 2)]);
      end else begin
        c = u8_t'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_BSLASH) c = "q";
        q.push_back(c);
      end
    end
    q.push_back(CH_QUOTE);
  endtask

  task automatic add_number(ref u8_t q[$]);
    if ($urandom_range(0, 1)) q.push_back("-");
    if ($urandom_range(0, 3) == 0) begin
      q.push_back("0");
    end else begin
      q.push_back(u8_t'($urandom_range("1", "9")));
      repeat ($urandom_range(0, 3)) q.push_back(u8_t'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 2) == 0) begin
      q.push_back(".");
      repeat ($urandom_range(1, 3)) q.push_back(u8_t'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 2) == 0) begin
      q.push_back($urandom_range(0, 1) ? "e" : CH_UPPER_E);
      case ($urandom_range(0, 2))
        0: q.push_back("+");
        1: q.push_back("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) q.push_back(u8_t'($urandom_range("0", "9")));
    end
  endtask

  task automatic add_scalar(ref u8_t q[$]);
    string w;
    case ($urandom_range(0, 3))
      0: add_string(q);
      1: add_number(q);
      default: begin
        case ($urandom_range(0, 2))
          0: w = "true";
          1: w = "false";
          default: w = "null";
        endcase
        for (int i = 0; i < w.len(); i++) q.push_back(w[i]);
      end
    endcase
  endtask

  // well-formed object with random content, nesting up to max_depth
  task automatic build_json(ref u8_t q[$], input int max_depth);
    bit kinds[$];
    bit fresh[$];
    int budget;
    int k;
    budget = $urandom_range(1, 8);
    q.delete();
    add_space(q);
    q.push_back("{");
    kinds.push_back(1);
    fresh.push_back(1);
    while (kinds.size() > 0) begin
      if (budget <= 0 || $urandom_range(0, 99) < 25) begin
        add_space(q);
        q.push_back(kinds[kinds.size()-1] ? "}" : "]");
        void'(kinds.pop_back());
        void'(fresh.pop_back());
      end else begin
        budget--;
        if (!fresh[fresh.size()-1]) q.push_back(",");
        fresh[fresh.size()-1] = 0;
        add_space(q);
        if (kinds[kinds.size()-1]) begin
          add_string(q);
          add_space(q);
          q.push_back(":");
          add_space(q);
        end
        k = $urandom_range(0, 5);
        if (k < 2 && kinds.size() < max_depth) begin
          q.push_back(k == 0 ? "{" : "[");
          kinds.push_back(k == 0);
          fresh.push_back(1);
        end else begin
          add_scalar(q);
          add_space(q);
        end
      end
    end
    add_space(q);
  endtask

  task automatic test_directed();
    send_str("{}");
    send_str(" \t{\n}\r ");
    send_str("{\"t\":true,\"f\":false,\"n\":null}");
    send_str("{\"a\":-0.5e+10,\"b\":120E-3,\"c\":7,\"d\":0}");
    send_str("{\"s\":\"x\\\\\\\"y\\\\\",\"k\":[1,2,{\"b\":[]}]}");
    send_str("[1]");
    send_str("{\"a\":01}");
    send_str("{\"a\":tru}");
    send_str("{\"a\":\"abc");
    send_str("{\"a\":12");
    send_str("{\"a\":[1");
    send_str("{\"a\":1} x");
    send_str("{\"a\":1.}");
    send_str("{\"a\":-}");
    send_str("{\"a\":1e}");
    send_str("{,}");
    send_str("{\"a\" 1}");
    send_str("{");
    send_str("x");
    send_str("{\"a\":[]]}");
  endtask

  task automatic test_nesting();
    set_limit(7'd1);
    send_str("{}");
    send_str("{\"a\":[]}");
    set_limit(7'd0);
    send_str("{}");
    set_limit(7'd2);
    send_str("{\"a\":{}}");
    send_str("{\"a\":[[]]}");
    set_limit(7'd64);
    send_nest(63);
    send_nest(64);
    set_limit(7'd127);
    send_nest(63);
    send_nest(64);
    set_limit(7'd64);
  endtask

  task automatic test_long_text();
    u8_t q[$];
    no_gaps = 1;
    q.push_back("{");
    repeat (80) q.push_back(CH_SPACE);
    q.push_back("}");
    send_text(q);
    q[q.size()-1] = "x";
    send_text(q);
    q[1] = CH_QUOTE;
    void'(q.pop_back());
    send_text(q);
    no_gaps = 0;
  endtask

  task automatic test_random();
    u8_t q[$];
    int r;
    int cut;
    logic [6:0] lims [6];
    lims = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd64, 7'd100};
    while (bytes_sent < 1600) begin
      if (texts_sent % 12 == 0) set_limit(lims[$urandom_range(0, 5)]);
      no_gaps = $urandom_range(0, 3) == 0;
      r = $urandom_range(0, 99);
      if (r < 90) build_json(q, $urandom_range(1, 6));
      if (r >= 90) begin
        q.delete();
        repeat ($urandom_range(1, 10)) q.push_back(u8_t'($urandom_range(0, 255)));
      end else if (r >= 80) begin
        cut = $urandom_range(1, q.size() - 1 > 0 ? q.size() - 1 : 1);
        while (q.size() > cut) void'(q.pop_back());
      end else if (r >= 72) begin
        q[$urandom_range(0, q.size() - 1)] = u8_t'($urandom_range(0, 255));
      end else if (r >= 66) begin
        q.push_back($urandom_range(0, 1) ? "x" : "{");
      end
      send_text(q);
    end
    no_gaps = 0;
  endtask

  always @(posedge clk) begin
    out_item_t v;
    if (!rst) begin
      if (pop && !empty) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $error("result with no text pending: valid %0d offset %0d",
                 out_item.json_valid, out_item.error_offset);
          fail_cnt++;
        end else begin
          v = verdict_q.pop_front();
          if (out_item.json_valid !== v.json_valid) begin
            $error("json_valid expected %0d actual %0d", v.json_valid, out_item.json_valid);
            fail_cnt++;
          end
          if (out_item.error_offset !== v.error_offset) begin
            $error("error_offset expected %0d actual %0d", v.error_offset,
                   out_item.error_offset);
            fail_cnt++;
          end
          if (out_item.depth_overflow !== v.depth_overflow) begin
            $error("depth_overflow expected %0d actual %0d", v.depth_overflow,
                   out_item.depth_overflow);
            fail_cnt++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) pop_calm = ~pop_calm;
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (!pop_calm && $urandom_range(0, 99) < 15) begin
        pop_hold = $urandom_range(0, 99) < 85 ? $urandom_range(0, 3) : $urandom_range(15, 50);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_nesting();
    test_long_text();
    test_random();
    wait_idle();
    $display("covered %0d texts, %0d bytes, %0d verdicts checked", texts_sent, bytes_sent,
             verdicts_seen);
    $display("nesting limits 0 to 127, whitespace runs, cut off and corrupt texts");
    if (fail_cnt == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/jsv_pkg.sv
design/jsv_front.sv
design/jsv_back.sv
design/json_syntax_validator_unit.sv
dv/tb_top.sv
